>>> rtl/core/lcd_window_command_generator_assert.svh
// Assertion macros for the LCD window command generator.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef LCD_WINDOW_COMMAND_GENERATOR_ASSERT_SVH
`define LCD_WINDOW_COMMAND_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define LWCG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lwcg assertion failed");
// Check that a condition never holds outside reset.
`define LWCG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lwcg forbidden condition seen");
`else
`define LWCG_ASSERT(lbl, prop)
`define LWCG_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> rtl/core/lwcg_pkg.sv
// Shared types and constants of the LCD window command generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lwcg_pkg;

  localparam int unsigned CoordBits   = 12;  // coordinate bits used from each input
  localparam int unsigned InBits      = 12;  // input field width
  localparam int unsigned AddrBits    = 16;  // bus address width, arithmetic wraps here
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 13;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] CmdColSet = 8'h2A;
  localparam logic [7:0] CmdRowSet = 8'h2B;
  localparam logic [7:0] CmdMemWr  = 8'h2C;

  localparam logic [5:0] Bits8  = 6'd8;
  localparam logic [5:0] Bits16 = 6'd16;
  localparam logic [5:0] Bits32 = 6'd32;

  typedef enum logic [CfgIdxBits-1:0] {
    RegRotation       = 3'd0,
    RegOffsetRotation = 3'd1,
    RegBus16          = 3'd2,
    RegPanelWidth     = 3'd3,
    RegPanelHeight    = 3'd4,
    RegOffsetX        = 3'd5,
    RegOffsetY        = 3'd6
  } cfg_reg_e;

  // One classified window, ready for serialization.
  typedef struct packed {
    logic                bus16;
    logic                pad;
    logic                col_en;
    logic                row_en;
    logic [AddrBits-1:0] col_s;
    logic [AddrBits-1:0] col_e;
    logic [AddrBits-1:0] row_s;
    logic [AddrBits-1:0] row_e;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/lcd_window_command_generator.sv
// Top level of the LCD window command generator: front end, window queue, back end.
// Depends on lwcg_pkg, lwcg_front, lwcg_queue, lwcg_back and the assertion header.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------
//   in      | in_valid_i / in_stall_o| x_start_i y_start_i x_end_i y_end_i align_pending_i
//   out     | out_valid_o/out_stall_i| is_data_o bus_word_o bit_count_o last_o
//   cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// Each window yields one to eight bus writes, one per cycle from the output register while
// out_stall_i is low; the back end's step sequencer sets the number of writes.
// A window is accepted in any cycle the two-entry queue has room, also while results wait.
// Reset loads the register defaults and marks the address cache empty; no clearing pass.
// out_stall_i holds the output register and the sequencer; the queue then fills and
// in_stall_o rises. Config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

`include "lcd_window_command_generator_assert.svh"

module lcd_window_command_generator import lwcg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [InBits-1:0]      x_start_i,
  input  wire logic [InBits-1:0]      y_start_i,
  input  wire logic [InBits-1:0]      x_end_i,
  input  wire logic [InBits-1:0]      y_end_i,
  input  wire logic                   align_pending_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        is_data_o,
  output logic [31:0]                 bus_word_o,
  output logic [5:0]                  bit_count_o,
  output logic                        last_o
);

  logic q_push, q_pop, q_full, q_empty;
  logic out_is_cmd;
  job_t job_in, job_head;

  // Register writes never back-pressure.
  assign cfg_ready_o = 1'b1;
  // Stall the input only while the queue is full.
  assign in_stall_o  = q_full;

  // Classify the window: rotate, check the cache, mirror and offset.
  lwcg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .align_pending_i (align_pending_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .job_o           (job_in)
  );

  // Decouple classification from serialization.
  lwcg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (job_head)
  );

  // Serialize the head window into bus writes; drop it after the memory-write command.
  lwcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (job_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_data_o   (is_data_o),
    .bus_word_o  (bus_word_o),
    .bit_count_o (bit_count_o),
    .last_o      (last_o)
  );

  // A command write: 8 or 16 bits, never data.
  assign out_is_cmd = !is_data_o && (bit_count_o == Bits8 || bit_count_o == Bits16);

  `LWCG_ASSERT_NEVER(a_pop_empty, q_pop && q_empty)
  `LWCG_ASSERT_NEVER(a_push_full, q_push && q_full)
  `LWCG_ASSERT(a_last_is_cmd, (out_valid_o && last_o) |-> out_is_cmd)
  `LWCG_ASSERT(a_pop_shows_last, q_pop |=> (out_valid_o && last_o))

endmodule

`default_nettype wire

>>> rtl/core/lwcg_front.sv
// Front end: configuration registers, address cache and window classification.
// Depends on lwcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwcg_front import lwcg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  input  wire logic [InBits-1:0]      x_start_i,
  input  wire logic [InBits-1:0]      y_start_i,
  input  wire logic [InBits-1:0]      x_end_i,
  input  wire logic [InBits-1:0]      y_end_i,
  input  wire logic                   align_pending_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output job_t                        job_o
);

  logic [2:0]          rotation_q, mount_rot_q;
  logic                bus16_q;
  logic [12:0]         panel_width_q, panel_height_q;
  logic [11:0]         offset_x_q, offset_y_q;
  logic                cache_valid_q, cache_valid_d;
  logic [CoordBits-1:0] cache_col_s_q, cache_col_e_q, cache_row_s_q, cache_row_e_q;

  logic [2:0]           eff_rot;
  logic                 col_mirror, row_mirror;
  logic [CoordBits-1:0] xs, xe, ys, ye;
  logic [CoordBits-1:0] cs, ce, rs, re;
  logic [AddrBits-1:0]  pw, ph;
  logic [AddrBits-1:0]  cs_m, ce_m, rs_m, re_m;
  logic                 col_hit, row_hit;
  logic                 cfg_hit;

  assign xs = x_start_i[CoordBits-1:0];
  assign xe = x_end_i[CoordBits-1:0];
  assign ys = y_start_i[CoordBits-1:0];
  assign ye = y_end_i[CoordBits-1:0];

  assign eff_rot = {rotation_q[2] ^ mount_rot_q[2],
                    2'(rotation_q[1:0] + mount_rot_q[1:0])};
  assign col_mirror = eff_rot inside {3'd1, 3'd2, 3'd6, 3'd7};
  assign row_mirror = eff_rot inside {3'd2, 3'd3, 3'd4, 3'd7};

  // Odd quarter turns swap the axes.
  assign cs = eff_rot[0] ? ys : xs;
  assign ce = eff_rot[0] ? ye : xe;
  assign rs = eff_rot[0] ? xs : ys;
  assign re = eff_rot[0] ? xe : ye;

  assign col_hit = cache_valid_q && (cs == cache_col_s_q) && (ce == cache_col_e_q);
  assign row_hit = cache_valid_q && (rs == cache_row_s_q) && (re == cache_row_e_q);

  assign pw = AddrBits'(panel_width_q);
  assign ph = AddrBits'(panel_height_q);

  // Mirror swaps the ends and reflects against the panel size.
  assign cs_m = col_mirror ? (pw - AddrBits'(ce) - AddrBits'(1)) : AddrBits'(cs);
  assign ce_m = col_mirror ? (pw - AddrBits'(cs) - AddrBits'(1)) : AddrBits'(ce);
  assign rs_m = row_mirror ? (ph - AddrBits'(re) - AddrBits'(1)) : AddrBits'(rs);
  assign re_m = row_mirror ? (ph - AddrBits'(rs) - AddrBits'(1)) : AddrBits'(re);

  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    job_o.bus16  = bus16_q;
    job_o.pad    = bus16_q && align_pending_i;
    job_o.col_en = !col_hit;
    job_o.row_en = !row_hit;
    job_o.col_s  = cs_m + AddrBits'(offset_x_q);
    job_o.col_e  = ce_m + AddrBits'(offset_x_q);
    job_o.row_s  = rs_m + AddrBits'(offset_y_q);
    job_o.row_e  = re_m + AddrBits'(offset_y_q);
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegRotation, RegOffsetRotation, RegBus16, RegPanelWidth,
        RegPanelHeight, RegOffsetX, RegOffsetY: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Any listed register write drops the cache; an accepted window fills it.
  always_comb begin
    cache_valid_d = cache_valid_q;
    if (cfg_hit) begin
      cache_valid_d = 1'b0;
    end else if (push_o) begin
      cache_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q     <= 3'd0;
      mount_rot_q    <= 3'd0;
      bus16_q        <= 1'b0;
      panel_width_q  <= 13'd800;
      panel_height_q <= 13'd480;
      offset_x_q     <= 12'd0;
      offset_y_q     <= 12'd0;
      cache_valid_q  <= 1'b0;
    end else begin
      cache_valid_q <= cache_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegRotation:       rotation_q     <= cfg_data_i[2:0];
          RegOffsetRotation: mount_rot_q    <= cfg_data_i[2:0];
          RegBus16:          bus16_q        <= cfg_data_i[0];
          RegPanelWidth:     panel_width_q  <= cfg_data_i[12:0];
          RegPanelHeight:    panel_height_q <= cfg_data_i[12:0];
          RegOffsetX:        offset_x_q     <= cfg_data_i[11:0];
          RegOffsetY:        offset_y_q     <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  // Cache holds the swapped, unmirrored ranges.
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      cache_col_s_q <= cs;
      cache_col_e_q <= ce;
      cache_row_s_q <= rs;
      cache_row_e_q <= re;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lwcg_queue.sv
// Short queue of classified windows between front and back end.
// Depends on lwcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwcg_queue import lwcg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output job_t      head_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  job_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    ptr_inc = (p == PtrBits'(QueueDepth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  assign full_o  = (count_q == CntBits'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lwcg_back.sv
// Back end: walks the queue head through its bus writes, one per cycle while out_stall_i is low.
// Depends on lwcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwcg_back import lwcg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  wire job_t        head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_data_o,
  output logic [31:0]      bus_word_o,
  output logic [5:0]       bit_count_o,
  output logic             last_o
);

  typedef enum logic [8:0] {
    StStart  = 9'b000000001,
    StPad    = 9'b000000010,
    StColCmd = 9'b000000100,
    StColS   = 9'b000001000,
    StColE   = 9'b000010000,
    StRowCmd = 9'b000100000,
    StRowS   = 9'b001000000,
    StRowE   = 9'b010000000,
    StMemWr  = 9'b100000000
  } step_e;

  step_e       step_q, step_d, cur;
  logic        advance, emit;
  logic        valid_q, valid_d;
  logic        is_data_q, is_data_d, last_q, last_d;
  logic [31:0] word_q, word_d;
  logic [5:0]  bits_q, bits_d;

  function automatic logic [31:0] word16(input logic [AddrBits-1:0] v);
    word16 = {v[7:0], 8'h00, v[15:8], 8'h00};
  endfunction

  function automatic logic [31:0] pack8(input logic [AddrBits-1:0] s,
                                        input logic [AddrBits-1:0] e);
    pack8 = {e[7:0], e[15:8], s[7:0], s[15:8]};
  endfunction

  function automatic step_e after_col(input job_t j);
    after_col = j.row_en ? StRowCmd : StMemWr;
  endfunction

  function automatic step_e first_step(input job_t j);
    if (j.pad) begin
      first_step = StPad;
    end else if (j.col_en) begin
      first_step = StColCmd;
    end else begin
      first_step = after_col(j);
    end
  endfunction

  function automatic step_e next_step(input step_e s, input job_t j);
    case (s)
      StPad:    next_step = j.col_en ? StColCmd : after_col(j);
      StColCmd: next_step = StColS;
      StColS:   next_step = j.bus16 ? StColE : after_col(j);
      StColE:   next_step = after_col(j);
      StRowCmd: next_step = StRowS;
      StRowS:   next_step = j.bus16 ? StRowE : StMemWr;
      StRowE:   next_step = StMemWr;
      default:  next_step = StStart;
    endcase
  endfunction

  assign cur     = (step_q == StStart) ? first_step(head_i) : step_q;
  assign advance = !valid_q || !out_stall_i;
  assign emit    = advance && !q_empty_i;
  assign pop_o   = emit && (cur == StMemWr);

  always_comb begin
    is_data_d = 1'b0;
    word_d    = 32'd0;
    bits_d    = Bits8;
    last_d    = 1'b0;
    case (cur)
      StPad: begin
        is_data_d = 1'b1;
      end
      StColCmd: begin
        word_d = head_i.bus16 ? {16'd0, CmdColSet, 8'd0} : {24'd0, CmdColSet};
        bits_d = head_i.bus16 ? Bits16 : Bits8;
      end
      StColS: begin
        is_data_d = 1'b1;
        word_d    = head_i.bus16 ? word16(head_i.col_s) : pack8(head_i.col_s, head_i.col_e);
        bits_d    = Bits32;
      end
      StColE: begin
        is_data_d = 1'b1;
        word_d    = word16(head_i.col_e);
        bits_d    = Bits32;
      end
      StRowCmd: begin
        word_d = head_i.bus16 ? {16'd0, CmdRowSet, 8'd0} : {24'd0, CmdRowSet};
        bits_d = head_i.bus16 ? Bits16 : Bits8;
      end
      StRowS: begin
        is_data_d = 1'b1;
        word_d    = head_i.bus16 ? word16(head_i.row_s) : pack8(head_i.row_s, head_i.row_e);
        bits_d    = Bits32;
      end
      StRowE: begin
        is_data_d = 1'b1;
        word_d    = word16(head_i.row_e);
        bits_d    = Bits32;
      end
      StMemWr: begin
        word_d = head_i.bus16 ? {16'd0, CmdMemWr, 8'd0} : {24'd0, CmdMemWr};
        bits_d = head_i.bus16 ? Bits16 : Bits8;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    step_d  = emit ? next_step(cur, head_i) : step_q;
    valid_d = advance ? emit : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StStart;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_data_q <= is_data_d;
      word_q    <= word_d;
      bits_q    <= bits_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign is_data_o   = is_data_q;
  assign bus_word_o  = word_q;
  assign bit_count_o = bits_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for lcd_window_command_generator: drives windows and register writes,
// predicts every bus write in a small scoreboard class and compares the outputs item by item.
// Depends on lwcg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import lwcg_pkg::*;

  // Index past the end of the register list: the block must ignore it.
  localparam logic [CfgIdxBits-1:0] RegUnused = 3'd7;

  // Effective rotations that mirror the column range and the row range.
  localparam logic [7:0] ColMirrorRots = 8'b1100_0110;
  localparam logic [7:0] RowMirrorRots = 8'b1001_1100;
  localparam logic [15:0] CacheEmpty = 16'h7FFF;

  localparam logic [InBits-1:0] CoordMax = 12'hFFF;
  localparam logic [CfgDataBits-1:0] PanelMax = 13'd4096;

  typedef struct packed {
    logic [InBits-1:0] x_start;
    logic [InBits-1:0] y_start;
    logic [InBits-1:0] x_end;
    logic [InBits-1:0] y_end;
    logic              align_pending;
  } window_t;

  typedef struct packed {
    logic        is_data;
    logic [31:0] word;
    logic [5:0]  bits;
    logic        is_last;
  } bus_write_t;

  // Predict the bus writes of each accepted window and check them in order.
  class window_scoreboard;
    logic [2:0]             rotation;
    logic [2:0]             mount_rot;
    logic                   bus16;
    logic [CfgDataBits-1:0] panel_w;
    logic [CfgDataBits-1:0] panel_h;
    logic [11:0]            off_x;
    logic [11:0]            off_y;
    logic [15:0]            col_s_seen, col_e_seen, row_s_seen, row_e_seen;
    bus_write_t             expected_writes[$];
    int unsigned            errors;

    function new();
      rotation  = '0;
      mount_rot = '0;
      bus16     = 1'b0;
      panel_w   = 13'd800;
      panel_h   = 13'd480;
      off_x     = '0;
      off_y     = '0;
      errors    = 0;
      forget_window();
    endfunction

    function void forget_window();
      col_s_seen = CacheEmpty;
      col_e_seen = CacheEmpty;
      row_s_seen = CacheEmpty;
      row_e_seen = CacheEmpty;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        RegRotation:       rotation  = data[2:0];
        RegOffsetRotation: mount_rot = data[2:0];
        RegBus16:          bus16     = data[0];
        RegPanelWidth:     panel_w   = data;
        RegPanelHeight:    panel_h   = data;
        RegOffsetX:        off_x     = data[11:0];
        RegOffsetY:        off_y     = data[11:0];
        default:           return;
      endcase
      forget_window();
    endfunction

    function void push_write(logic is_data, logic [31:0] word, logic [5:0] bits,
                             logic is_last);
      expected_writes.push_back({is_data, word, bits, is_last});
    endfunction

    // One address-set command with its start and end address.
    function void push_range(logic [7:0] cmd, logic [15:0] s, logic [15:0] e);
      if (bus16) begin
        push_write(1'b0, {16'h0, cmd, 8'h00}, Bits16, 1'b0);
        push_write(1'b1, {s[7:0], 8'h00, s[15:8], 8'h00}, Bits32, 1'b0);
        push_write(1'b1, {e[7:0], 8'h00, e[15:8], 8'h00}, Bits32, 1'b0);
      end else begin
        push_write(1'b0, {24'h0, cmd}, Bits8, 1'b0);
        push_write(1'b1, {e[7:0], e[15:8], s[7:0], s[15:8]}, Bits32, 1'b0);
      end
    endfunction

    function void note_window(window_t w);
      logic [2:0]  eff;
      logic [15:0] xs, ys, xe, ye, s, e;
      eff = {rotation[2] ^ mount_rot[2], rotation[1:0] + mount_rot[1:0]};
      if (bus16 && w.align_pending)
        push_write(1'b1, 32'd0, Bits8, 1'b0);
      // Odd rotations swap the axes before the cache compare.
      if (eff[0]) begin
        xs = {4'h0, w.y_start};
        xe = {4'h0, w.y_end};
        ys = {4'h0, w.x_start};
        ye = {4'h0, w.x_end};
      end else begin
        xs = {4'h0, w.x_start};
        xe = {4'h0, w.x_end};
        ys = {4'h0, w.y_start};
        ye = {4'h0, w.y_end};
      end
      if (xs != col_s_seen || xe != col_e_seen) begin
        col_s_seen = xs;
        col_e_seen = xe;
        s = xs;
        e = xe;
        if (ColMirrorRots[eff]) begin
          s = {3'b000, panel_w} - xe - 16'd1;
          e = {3'b000, panel_w} - xs - 16'd1;
        end
        push_range(CmdColSet, s + {4'h0, off_x}, e + {4'h0, off_x});
      end
      if (ys != row_s_seen || ye != row_e_seen) begin
        row_s_seen = ys;
        row_e_seen = ye;
        s = ys;
        e = ye;
        if (RowMirrorRots[eff]) begin
          s = {3'b000, panel_h} - ye - 16'd1;
          e = {3'b000, panel_h} - ys - 16'd1;
        end
        push_range(CmdRowSet, s + {4'h0, off_y}, e + {4'h0, off_y});
      end
      if (bus16)
        push_write(1'b0, {16'h0, CmdMemWr, 8'h00}, Bits16, 1'b1);
      else
        push_write(1'b0, {24'h0, CmdMemWr}, Bits8, 1'b1);
    endfunction

    function void field_check(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_write(bus_write_t got);
      bus_write_t exp_w;
      if (expected_writes.size() == 0) begin
        $display("%0t: bus write with none expected, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      exp_w = expected_writes.pop_front();
      field_check("is_data", exp_w.is_data, got.is_data);
      field_check("bus_word", exp_w.word, got.word);
      field_check("bit_count", exp_w.bits, got.bits);
      field_check("last", exp_w.is_last, got.is_last);
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index  = '0;
  logic [CfgDataBits-1:0] cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  window_t                in_window  = '0;
  logic                   out_stall  = 1'b0;

  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        is_data_o;
  logic [31:0] bus_word_o;
  logic [5:0]  bit_count_o;
  logic        last_o;

  int send_idle_pct = 0;
  int out_stall_pct = 0;

  window_scoreboard sb;

  lcd_window_command_generator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .x_start_i       (in_window.x_start),
    .y_start_i       (in_window.y_start),
    .x_end_i         (in_window.x_end),
    .y_end_i         (in_window.y_end),
    .align_pending_i (in_window.align_pending),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .is_data_o       (is_data_o),
    .bus_word_o      (bus_word_o),
    .bit_count_o     (bit_count_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the output side at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Sample every handshake on the clock edge, before the block updates its outputs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o)
        sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall_o)
        sb.note_window(in_window);
      if (out_valid_o && !out_stall)
        sb.check_write({is_data_o, bus_word_o, bit_count_o, last_o});
    end
  end

  // Hold valid high after the handshake; the next call or cfg_done decides whether to drop it.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  // Insert a random idle gap, then present the window until it is taken.
  task automatic send_window(window_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_window <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every predicted write has come out, plus a margin.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic window_t mk_window(logic [InBits-1:0] xs, logic [InBits-1:0] ys,
                                        logic [InBits-1:0] xe, logic [InBits-1:0] ye,
                                        logic align);
    return {xs, ys, xe, ye, align};
  endfunction

  // Favor the range extremes, otherwise any coordinate.
  function automatic logic [InBits-1:0] rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return CoordMax;
    return InBits'($urandom_range(CoordMax));
  endfunction

  // Reuse the previous column or row pair often, so cache hits and misses both occur.
  function automatic window_t random_window(window_t prev);
    window_t w;
    int      sel;
    w = mk_window(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  1'($urandom_range(1)));
    sel = $urandom_range(9);
    if (sel < 3) begin
      w.x_start = prev.x_start;
      w.x_end   = prev.x_end;
    end else if (sel < 5) begin
      w.y_start = prev.y_start;
      w.y_end   = prev.y_end;
    end else if (sel == 5) begin
      w.x_start = prev.x_start;
      w.x_end   = prev.x_end;
      w.y_start = prev.y_start;
      w.y_end   = prev.y_end;
    end
    return w;
  endfunction

  function automatic logic [CfgDataBits-1:0] rand_reg_value(logic [CfgIdxBits-1:0] idx);
    int sel;
    sel = $urandom_range(3);
    case (idx)
      RegRotation, RegOffsetRotation: return CfgDataBits'($urandom_range(7));
      RegBus16:                       return CfgDataBits'($urandom_range(1));
      RegPanelWidth, RegPanelHeight: begin
        if (sel == 0) return 13'd1;
        if (sel == 1) return PanelMax;
        return CfgDataBits'($urandom_range(PanelMax, 1));
      end
      default: begin
        if (sel == 0) return '0;
        if (sel == 1) return CfgDataBits'(CoordMax);
        return CfgDataBits'($urandom_range(CoordMax));
      end
    endcase
  endfunction

  task automatic random_config();
    for (int i = RegRotation; i <= RegOffsetY; i++)
      write_reg(CfgIdxBits'(i), rand_reg_value(CfgIdxBits'(i)));
    if ($urandom_range(3) == 0)
      write_reg(RegUnused, CfgDataBits'($urandom_range(13'h1FFF)));
    cfg_done();
  endtask

  initial begin
    window_t prev;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, 8-bit bus: first window, a full cache hit, extremes, single-axis changes.
    // align_pending must be ignored on the 8-bit bus.
    send_window(mk_window('0, '0, '0, '0, 1'b0));
    send_window(mk_window('0, '0, '0, '0, 1'b0));
    send_window(mk_window(CoordMax, CoordMax, CoordMax, CoordMax, 1'b1));
    send_window(mk_window(CoordMax, '0, CoordMax, '0, 1'b0));
    send_window(mk_window(12'hAAA, '0, 12'h555, '0, 1'b1));
    send_window(mk_window(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b0));

    // 16-bit bus with extreme panel size and offsets.
    drain();
    write_reg(RegBus16, 13'd1);
    write_reg(RegPanelWidth, PanelMax);
    write_reg(RegPanelHeight, 13'd1);
    write_reg(RegOffsetX, CfgDataBits'(CoordMax));
    write_reg(RegOffsetY, CfgDataBits'(CoordMax));
    cfg_done();
    send_window(mk_window(12'h123, 12'h456, 12'h789, 12'hABC, 1'b1));
    send_window(mk_window(12'h123, 12'h456, 12'h789, 12'hABC, 1'b0));
    send_window(mk_window(CoordMax, CoordMax, '0, '0, 1'b1));

    // A write past the register list must keep the cache.
    drain();
    write_reg(RegUnused, 13'h1FFF);
    cfg_done();
    send_window(mk_window(CoordMax, CoordMax, '0, '0, 1'b1));

    // Walk every effective rotation.
    for (int r = 1; r < 8; r++) begin
      drain();
      write_reg(RegRotation, CfgDataBits'(r));
      cfg_done();
      send_window(mk_window(InBits'(r * 512), InBits'(CoordMax - r * 512),
                            InBits'(r * 300), InBits'(r * 37), r[0]));
    end

    // Mounting rotation combined with the requested one, back on the 8-bit bus.
    drain();
    write_reg(RegBus16, 13'd0);
    write_reg(RegOffsetRotation, 13'd5);
    write_reg(RegRotation, 13'd6);
    write_reg(RegPanelWidth, 13'd1);
    write_reg(RegPanelHeight, PanelMax);
    write_reg(RegOffsetX, '0);
    write_reg(RegOffsetY, '0);
    cfg_done();
    send_window(mk_window(CoordMax, 12'd1, '0, 12'd4094, 1'b1));

    // Random part: four idling phases, each with several register settings.
    prev = '0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin send_idle_pct = 65; out_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  out_stall_pct = 65; end
        default: begin send_idle_pct = 10; out_stall_pct = 10; end
      endcase
      repeat (4) begin
        drain();
        random_config();
        repeat (12) begin
          prev = random_window(prev);
          send_window(prev);
        end
      end
    end

    drain();
    if (sb.errors == 0)
      $display("** lcd_window_command_generator: PASSED **");
    else
      $display("** lcd_window_command_generator: FAILED **");
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin
    #2_000_000;
    $display("** lcd_window_command_generator: FAILED **");
    $finish;
  end

endmodule
